// File: hdl/cvp_pkg.sv
// ============================================================================
// cvp_pkg
// Shared types and constants for the cylinder vertex pick block.
// ============================================================================
package cvp_pkg;

	localparam int VTX_W    = 32;
	localparam int IDX_W    = 20;
	localparam int AXIS_W   = 18;
	localparam int RAD_W    = 63;
	localparam int APB_DW   = 64;
	localparam int APB_AW   = 6;
	localparam int REG_LSB  = 3;

	typedef enum logic [2:0] {
		REG_ORIGIN_X  = 3'd0,
		REG_ORIGIN_Y  = 3'd1,
		REG_ORIGIN_Z  = 3'd2,
		REG_AXIS_DX   = 3'd3,
		REG_AXIS_DY   = 3'd4,
		REG_AXIS_DZ   = 3'd5,
		REG_RADIUS_SQ = 3'd6
	} cvp_reg_t;

	typedef struct packed {
		logic signed [VTX_W-1:0]  origin_x;
		logic signed [VTX_W-1:0]  origin_y;
		logic signed [VTX_W-1:0]  origin_z;
		logic signed [AXIS_W-1:0] axis_dx;
		logic signed [AXIS_W-1:0] axis_dy;
		logic signed [AXIS_W-1:0] axis_dz;
		logic [RAD_W-1:0]         radius_sq;
	} cvp_cfg_t;

	localparam cvp_cfg_t CFG_RESET = '{
		origin_x:  '0,
		origin_y:  '0,
		origin_z:  '0,
		axis_dx:   '0,
		axis_dy:   '0,
		axis_dz:   18'sd65536,
		radius_sq: '0
	};

endpackage

// File: hdl/cvp_cfg_regs.sv
// ============================================================================
// cvp_cfg_regs
// APB register file holding the pick axis, origin and squared radius.
// ============================================================================
module cvp_cfg_regs
	import cvp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cvp_cfg_t          cfg
);

	cvp_cfg_t cfg_q;
	cvp_reg_t reg_sel;
	logic     wr_en;

	assign reg_sel = cvp_reg_t'(paddr[APB_AW-1:REG_LSB]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_ORIGIN_X:  cfg_q.origin_x  <= pwdata[VTX_W-1:0];
				REG_ORIGIN_Y:  cfg_q.origin_y  <= pwdata[VTX_W-1:0];
				REG_ORIGIN_Z:  cfg_q.origin_z  <= pwdata[VTX_W-1:0];
				REG_AXIS_DX:   cfg_q.axis_dx   <= pwdata[AXIS_W-1:0];
				REG_AXIS_DY:   cfg_q.axis_dy   <= pwdata[AXIS_W-1:0];
				REG_AXIS_DZ:   cfg_q.axis_dz   <= pwdata[AXIS_W-1:0];
				REG_RADIUS_SQ: cfg_q.radius_sq <= pwdata[RAD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_ORIGIN_X:  prdata = APB_DW'(cfg_q.origin_x);
			REG_ORIGIN_Y:  prdata = APB_DW'(cfg_q.origin_y);
			REG_ORIGIN_Z:  prdata = APB_DW'(cfg_q.origin_z);
			REG_AXIS_DX:   prdata = APB_DW'(cfg_q.axis_dx);
			REG_AXIS_DY:   prdata = APB_DW'(cfg_q.axis_dy);
			REG_AXIS_DZ:   prdata = APB_DW'(cfg_q.axis_dz);
			REG_RADIUS_SQ: prdata = APB_DW'(cfg_q.radius_sq);
			default:       prdata = '0;
		endcase
	end

endmodule

// File: hdl/cvp_dist_pipe.sv
// ============================================================================
// cvp_dist_pipe
// Eight-stage pipeline computing the squared distance of a vertex from the
// pick axis and comparing it with the squared radius.
// ============================================================================
module cvp_dist_pipe
	import cvp_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cvp_cfg_t          cfg,
	input  logic              in_valid,
	input  logic [VTX_W-1:0]  vertex_x,
	input  logic [VTX_W-1:0]  vertex_y,
	input  logic [VTX_W-1:0]  vertex_z,
	input  logic [IDX_W-1:0]  vertex_index,
	output logic              out_valid,
	output logic [IDX_W-1:0]  result_index,
	output logic              picked
);

	localparam int DW = VTX_W + 1;
	localparam int WW = (COORD_WIDTH < DW) ? COORD_WIDTH : DW;
	localparam int PW = WW + AXIS_W;
	localparam int SW = WW + AXIS_W + 2;
	localparam int LW = 2 * WW + 2;
	localparam int EW = (LW > 64) ? LW : 65;
	localparam int ML = WW / 2;
	localparam int MH = WW - ML;
	localparam int QW = SW - 15;

	function automatic logic signed [WW-1:0] sat_w(input logic signed [DW-1:0] d);
		logic signed [WW-1:0] r;
		if (d[DW-1:WW-1] == {(DW-WW+1){d[DW-1]}}) begin
			r = d[WW-1:0];
		end else if (d[DW-1]) begin
			r = {1'b1, {(WW-1){1'b0}}};
		end else begin
			r = {1'b0, {(WW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic [WW-1:0] mag_w(input logic signed [WW-1:0] v);
		return v[WW-1] ? WW'(-v) : WW'(v);
	endfunction

	// Valid bits.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	// Payload.
	logic signed [WW-1:0] wx_s1, wy_s1, wz_s1;
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7, idx_s8;
	logic [2*WW-1:0]      sqx_s2, sqy_s2, sqz_s2;
	logic signed [PW-1:0] prx_s2, pry_s2, prz_s2;
	logic [LW-1:0]        len2_s3, len2_s4, len2_s5, len2_s6;
	logic signed [SW-1:0] dot_s3;
	logic [WW-1:0]        m_s4;
	logic                 big_s4, big_s5, big_s6;
	logic [2*MH-1:0]      hh_s5;
	logic [MH+ML-1:0]     hl_s5;
	logic [2*ML-1:0]      ll_s5;
	logic [2*WW-1:0]      proj2_s6;
	logic [EW-1:0]        dif_s7;
	logic                 zero_s7;
	logic                 picked_s8;

	logic [WW-1:0]        ax, ay, az;
	logic [SW-1:0]        dot_abs;
	logic [SW:0]          dot_rnd;
	logic [QW-1:0]        m_full;
	logic [MH-1:0]        m_hi;
	logic [ML-1:0]        m_lo;
	logic [EW:0]          dif_full;

	always_comb begin
		ax       = mag_w(wx_s1);
		ay       = mag_w(wy_s1);
		az       = mag_w(wz_s1);
		dot_abs  = dot_s3[SW-1] ? SW'(-dot_s3) : SW'(dot_s3);
		dot_rnd  = {1'b0, dot_abs} + (SW+1)'(1 << 15);
		m_full   = dot_rnd[SW:16];
		m_hi     = m_s4[WW-1:ML];
		m_lo     = m_s4[ML-1:0];
		dif_full = {1'b0, EW'(len2_s6)} - {1'b0, EW'(proj2_s6)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		// Offset from the origin, saturated to the coordinate width.
		wx_s1  <= sat_w($signed({vertex_x[VTX_W-1], vertex_x}) -
			$signed({cfg.origin_x[VTX_W-1], cfg.origin_x}));
		wy_s1  <= sat_w($signed({vertex_y[VTX_W-1], vertex_y}) -
			$signed({cfg.origin_y[VTX_W-1], cfg.origin_y}));
		wz_s1  <= sat_w($signed({vertex_z[VTX_W-1], vertex_z}) -
			$signed({cfg.origin_z[VTX_W-1], cfg.origin_z}));
		idx_s1 <= vertex_index;

		sqx_s2 <= (2*WW)'(ax) * (2*WW)'(ax);
		sqy_s2 <= (2*WW)'(ay) * (2*WW)'(ay);
		sqz_s2 <= (2*WW)'(az) * (2*WW)'(az);
		prx_s2 <= PW'(wx_s1) * PW'(cfg.axis_dx);
		pry_s2 <= PW'(wy_s1) * PW'(cfg.axis_dy);
		prz_s2 <= PW'(wz_s1) * PW'(cfg.axis_dz);
		idx_s2 <= idx_s1;

		len2_s3 <= LW'(sqx_s2) + LW'(sqy_s2) + LW'(sqz_s2);
		dot_s3  <= SW'(prx_s2) + SW'(pry_s2) + SW'(prz_s2);
		idx_s3  <= idx_s2;

		// A rounded projection at or above 2^WW always exceeds the length.
		m_s4    <= m_full[WW-1:0];
		big_s4  <= |m_full[QW-1:WW];
		len2_s4 <= len2_s3;
		idx_s4  <= idx_s3;

		hh_s5   <= (2*MH)'(m_hi) * (2*MH)'(m_hi);
		hl_s5   <= (MH+ML)'(m_hi) * (MH+ML)'(m_lo);
		ll_s5   <= (2*ML)'(m_lo) * (2*ML)'(m_lo);
		big_s5  <= big_s4;
		len2_s5 <= len2_s4;
		idx_s5  <= idx_s4;

		proj2_s6 <= ((2*WW)'(hh_s5) << (2*ML)) + ((2*WW)'(hl_s5) << (ML+1)) +
			(2*WW)'(ll_s5);
		big_s6   <= big_s5;
		len2_s6  <= len2_s5;
		idx_s6   <= idx_s5;

		dif_s7  <= dif_full[EW-1:0];
		zero_s7 <= big_s6 | dif_full[EW];
		idx_s7  <= idx_s6;

		if (zero_s7) begin
			picked_s8 <= |cfg.radius_sq;
		end else begin
			picked_s8 <= (dif_s7[EW-1:64] == '0) && (dif_s7[63:0] < 64'(cfg.radius_sq));
		end
		idx_s8 <= idx_s7;
	end

	assign out_valid    = vld_s8;
	assign result_index = idx_s8;
	assign picked       = picked_s8;

	a_idx_travels: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 |-> idx_s8 == $past(idx_s1, 7))
		else $error("vertex index did not follow its word through the pipeline");

	a_big_forces_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s6 && big_s6) |=> zero_s7)
		else $error("oversized projection did not clamp the distance to zero");

	a_zero_dot: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && dot_s3 == '0) |=> (m_s4 == '0 && !big_s4))
		else $error("zero projection rounded to a nonzero magnitude");

endmodule

// File: hdl/cylinder_vertex_pick.sv
// ============================================================================
// cylinder_vertex_pick
// A vertex taken at a rising edge passes through the registered stages s1 to s8
// of the pipeline, and the result strobe is the valid bit of stage s8.
// Throughput: one vertex per clock; busy never rises, since the eight-stage
// multiply and compare pipeline takes a new word every cycle.
// Reset clears the pipeline valid bits and loads the registers' defaults.
// ============================================================================
module cylinder_vertex_pick
	import cvp_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [VTX_W-1:0]  vertex_x,
	input  logic [VTX_W-1:0]  vertex_y,
	input  logic [VTX_W-1:0]  vertex_z,
	input  logic [IDX_W-1:0]  vertex_index,
	output logic              result_valid,
	output logic [IDX_W-1:0]  result_index,
	output logic              picked
);

	cvp_cfg_t cfg;

	assign busy = 1'b0;

	cvp_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cvp_dist_pipe #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (start & ~busy),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.vertex_index (vertex_index),
		.out_valid    (result_valid),
		.result_index (result_index),
		.picked       (picked)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for cylinder_vertex_pick. Vertices go in through the
// start/busy command port, and the pick registers are set over APB between
// phases. A fixed-point copy of the distance test predicts every picked flag.
// Each result strobe is checked against the oldest prediction. The run is a
// short directed set followed by random vertices, most clustered around the axis.
// ============================================================================
module tb;
	import cvp_pkg::*;

	localparam int COORD_W     = 32;
	localparam int SPARE_REG   = 7;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETUPS      = 12;
	localparam int PER_SETUP   = 158;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic             hit;
	} pick_t;

	class pick_tracker;
		logic signed [VTX_W-1:0]  org [3];
		logic signed [AXIS_W-1:0] dir [3];
		logic [RAD_W-1:0]         rad_sq;
		pick_t                    awaited [$];
		int                       errors;

		function void reset_regs();
			org[0] = CFG_RESET.origin_x;
			org[1] = CFG_RESET.origin_y;
			org[2] = CFG_RESET.origin_z;
			dir[0] = CFG_RESET.axis_dx;
			dir[1] = CFG_RESET.axis_dy;
			dir[2] = CFG_RESET.axis_dz;
			rad_sq = CFG_RESET.radius_sq;
		endfunction

		function void set_reg(cvp_reg_t r, logic [APB_DW-1:0] v);
			case (r)
				REG_ORIGIN_X:  org[0] = v[VTX_W-1:0];
				REG_ORIGIN_Y:  org[1] = v[VTX_W-1:0];
				REG_ORIGIN_Z:  org[2] = v[VTX_W-1:0];
				REG_AXIS_DX:   dir[0] = v[AXIS_W-1:0];
				REG_AXIS_DY:   dir[1] = v[AXIS_W-1:0];
				REG_AXIS_DZ:   dir[2] = v[AXIS_W-1:0];
				REG_RADIUS_SQ: rad_sq = v[RAD_W-1:0];
				default: ;
			endcase
		endfunction

		function logic predict_pick(logic [VTX_W-1:0] v [3]);
			longint       top;
			longint       w;
			longint       s;
			logic [127:0] len_sq;
			logic [127:0] proj_sq;
			logic [127:0] gap;
			logic [63:0]  mag;
			logic [63:0]  m;
			logic [63:0]  dist_sq;
			top = (longint'(1) << (COORD_W - 1)) - 1;
			len_sq = '0;
			s = 0;
			for (int i = 0; i < 3; i++) begin
				w = longint'($signed(v[i])) - longint'(org[i]);
				if (w > top)
					w = top;
				else if (w < -top - 1)
					w = -top - 1;
				mag = (w < 0) ? 64'(-w) : 64'(w);
				len_sq += 128'(mag) * 128'(mag);
				s += w * longint'(dir[i]);
			end
			mag = (s < 0) ? 64'(-s) : 64'(s);
			m = (mag + 64'h8000) >> 16;
			proj_sq = 128'(m) * 128'(m);
			if (proj_sq >= len_sq) begin
				dist_sq = '0;
			end else begin
				gap = len_sq - proj_sq;
				dist_sq = (gap[127:64] != 0) ? '1 : gap[63:0];
			end
			return dist_sq < {1'b0, rad_sq};
		endfunction

		function void note_vertex(logic [VTX_W-1:0] v [3], logic [IDX_W-1:0] idx);
			pick_t p;
			p.idx = idx;
			p.hit = predict_pick(v);
			awaited.push_back(p);
		endfunction

		function void check_pick(logic [IDX_W-1:0] idx, logic hit);
			pick_t want;
			if (awaited.size() == 0) begin
				$display("%0t: unrequested result, index %h picked %b", $time, idx, hit);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (idx !== want.idx) begin
				$display("%0t: result_index expected %h actual %h", $time, want.idx, idx);
				errors++;
			end
			if (hit !== want.hit) begin
				$display("%0t: picked expected %b actual %b (index %h)",
					$time, want.hit, hit, want.idx);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [APB_AW-1:0] paddr        = '0;
	logic [APB_DW-1:0] pwdata       = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              start        = 1'b0;
	logic              busy;
	logic [VTX_W-1:0]  vertex_x     = '0;
	logic [VTX_W-1:0]  vertex_y     = '0;
	logic [VTX_W-1:0]  vertex_z     = '0;
	logic [IDX_W-1:0]  vertex_index = '0;
	logic              result_valid;
	logic [IDX_W-1:0]  result_index;
	logic              picked;

	pick_tracker board = new;
	int          cycles = 0;
	longint      org_v [3];
	longint      dir_v [3];
	int          rad_k = 0;
	int          idle_pct [3] = '{37, 63, 0};

	cylinder_vertex_pick #(
		.COORD_WIDTH(COORD_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.start        (start),
		.busy         (busy),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_z     (vertex_z),
		.vertex_index (vertex_index),
		.result_valid (result_valid),
		.result_index (result_index),
		.picked       (picked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid)
			board.check_pick(result_index, picked);
	end

	task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic write_reg(cvp_reg_t r, longint val);
		logic [APB_DW-1:0] keep;
		logic [APB_DW-1:0] data;
		case (r)
			REG_AXIS_DX, REG_AXIS_DY, REG_AXIS_DZ: keep = (64'd1 << AXIS_W) - 1;
			REG_RADIUS_SQ:                         keep = (64'd1 << RAD_W) - 1;
			default:                               keep = (64'd1 << VTX_W) - 1;
		endcase
		data = 64'(val);
		if ($urandom_range(1))
			data = ({$urandom, $urandom} & ~keep) | (data & keep);
		apb_write(APB_AW'(int'(r) << REG_LSB), data);
		board.set_reg(r, data);
	endtask

	task automatic setup(longint ox, longint oy, longint oz, longint dx, longint dy,
			longint dz, longint rad);
		org_v = '{ox, oy, oz};
		dir_v = '{dx, dy, dz};
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_ORIGIN_Z, oz);
		write_reg(REG_AXIS_DX, dx);
		write_reg(REG_AXIS_DY, dy);
		write_reg(REG_AXIS_DZ, dz);
		write_reg(REG_RADIUS_SQ, rad);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (board.awaited.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (10) @(posedge clk);
	endtask

	task automatic send_vertex(logic [VTX_W-1:0] vx, logic [VTX_W-1:0] vy,
			logic [VTX_W-1:0] vz, logic [IDX_W-1:0] idx, int pct);
		logic [VTX_W-1:0] v [3];
		v = '{vx, vy, vz};
		start        <= 1'b1;
		vertex_x     <= vx;
		vertex_y     <= vy;
		vertex_z     <= vz;
		vertex_index <= idx;
		do @(posedge clk); while (busy);
		board.note_vertex(v, idx);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic random_item(int pct);
		logic [VTX_W-1:0] v [3];
		longint           t;
		longint           mask;
		longint           off;
		int               e;
		if ($urandom_range(99) < 25) begin
			for (int i = 0; i < 3; i++)
				v[i] = $urandom;
		end else begin
			t = longint'($signed($urandom)) >>> $urandom_range(31);
			e = rad_k + $urandom_range(2) - 1;
			if (e < 0)
				e = 0;
			mask = (longint'(1) << e) - 1;
			for (int i = 0; i < 3; i++) begin
				off = (longint'($urandom) & mask) - (mask >>> 1);
				v[i] = VTX_W'(org_v[i] + ((t * dir_v[i]) >>> 16) + off);
			end
		end
		send_vertex(v[0], v[1], v[2], IDX_W'($urandom), pct);
	endtask

	task automatic random_setup(int n);
		longint o [3];
		longint d [3];
		longint rad;
		longint sgn;
		int     p;
		for (int i = 0; i < 3; i++)
			o[i] = longint'($signed($urandom)) >>> $urandom_range(24);
		rad_k = $urandom_range(30);
		rad = (longint'(1) << (2 * rad_k)) |
			({$urandom, $urandom} & ((longint'(1) << (2 * rad_k)) - 1));
		d = '{0, 0, 0};
		p = $urandom_range(2);
		sgn = $urandom_range(1) ? 1 : -1;
		case (n % 6)
			0: d[p] = sgn * 65536;
			1: begin
				d[p] = sgn * 39322;
				d[(p + 1) % 3] = ($urandom_range(1) ? 1 : -1) * 52429;
			end
			2: for (int i = 0; i < 3; i++) d[i] = $signed(AXIS_W'($urandom));
			3: ;
			4: begin
				for (int i = 0; i < 3; i++)
					o[i] = $urandom_range(1) ? longint'(32'sh7FFF_FFFF)
						: longint'(32'sh8000_0000);
				d[p] = sgn * 65536;
				rad = 64'h7FFF_FFFF_FFFF_FFFF;
			end
			default: begin
				for (int i = 0; i < 3; i++)
					d[i] = ($urandom_range(1) ? 1 : -1) * 37837;
				rad = 0;
			end
		endcase
		setup(o[0], o[1], o[2], d[0], d[1], d[2], rad);
	endtask

	initial begin
		board.reset_regs();
		org_v = '{0, 0, 0};
		dir_v = '{0, 0, 65536};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 20'h00000, 37);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'hFFFFF, 37);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 20'hAAAAA, 37);
		settle();

		setup(longint'(32'sh8000_0000), longint'(32'sh7FFF_FFFF), 0, 65536, 0, 0,
			64'h7FFF_FFFF_FFFF_FFFF);
		apb_write(APB_AW'(SPARE_REG << REG_LSB), {$urandom, $urandom});
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 20'h55555, 37);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 20'h00001, 37);
		send_vertex(32'h8005_0000, 32'h7FFF_FFFF, 32'h0000_0000, 20'h00002, 37);
		send_vertex(32'h8001_2345, 32'h7FFF_FFFE, 32'h0000_0001, 20'h00003, 37);
		settle();

		setup(longint'(32'sh1234_5678), longint'(32'shF543_2110), 65536, 0, 0, 0,
			longint'(100) << 32);
		send_vertex(32'h1234_5678 + 32'h3_0000, 32'hF543_2110 + 32'h4_0000,
			32'h0001_0000, 20'h00010, 37);
		send_vertex(32'h1234_5678 + 32'h6_0000, 32'hF543_2110 + 32'h8_0000,
			32'h0001_0000, 20'h00011, 37);
		send_vertex(32'h1234_5678 + 32'h5_FFFF, 32'hF543_2110 + 32'h8_0000,
			32'h0001_0000, 20'h00012, 37);
		send_vertex(32'h1234_5678, 32'hF543_2110, 32'h0001_0000, 20'h00013, 37);
		settle();

		setup(0, 0, 0, 131071, -131072, 1, longint'(1) << 40);
		send_vertex(32'h0000_8000, 32'h0000_0000, 32'h0000_0000, 20'h00020, 37);
		send_vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 20'h00021, 37);
		send_vertex(32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000, 20'h00022, 37);
		send_vertex($urandom, $urandom, $urandom, 20'h00023, 37);
		settle();

		setup(0, 0, 0, 39322, 52429, 0, longint'(1) << 32);
		send_vertex(32'd117966, 32'd157287, 32'h0000_0000, 20'h00030, 37);
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 20'h00031, 37);
		send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 20'h00032, 37);
		settle();

		for (int n = 0; n < SETUPS; n++) begin
			random_setup(n);
			for (int k = 0; k < PER_SETUP; k++) begin
				if (k == PER_SETUP / 2)
					drain();
				random_item(idle_pct[n / 4]);
			end
			settle();
		end

		drain();
		repeat (16) @(posedge clk);
		if (board.errors == 0 && board.awaited.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
